/* design/aesbe_pkg.sv */
`timescale 1ns / 1ps
package aesbe_pkg;

   localparam int unsigned ROUNDS_DEFAULT = 10;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned BLOCK_W = 128;
   localparam int unsigned INDEX_W = 6;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_ENCRYPT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_ROUND = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   localparam logic [7:0] GF_POLY = 8'h1b;

   function automatic logic [7:0] sbox(input logic [7:0] v);
      logic [7:0] r;
      case (v)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // Byte n of a 128-bit block (byte 0 in the top bits): row n%4, column n/4.
   function automatic logic [7:0] blk_byte(input logic [BLOCK_W-1:0] b, input int n);
      return b[BLOCK_W-1-8*n -: 8];
   endfunction

endpackage

/* design/aesbe_round.sv */
`timescale 1ns / 1ps
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aesbe_round
   import aesbe_pkg::*;
(
   input  logic [BLOCK_W-1:0] state_in,
   input  logic [BLOCK_W-1:0] round_key,
   input  logic               mix_en,
   output logic [BLOCK_W-1:0] state_out
);

   logic [7:0] sb [16];
   logic [7:0] mc [16];

   // SubBytes with ShiftRows folded into the byte selection.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb[4*c+r] = sbox(blk_byte(state_in, 4*((c+r)%4)+r));
         end
      end
   end

   // MixColumns with matrix {2,3,1,1}, bypassed in the final round.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (mix_en) begin
            mc[4*c]   = xtime(sb[4*c]) ^ xtime(sb[4*c+1]) ^ sb[4*c+1]
                        ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c+1] = sb[4*c] ^ xtime(sb[4*c+1]) ^ xtime(sb[4*c+2])
                        ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c+2] = sb[4*c] ^ sb[4*c+1] ^ xtime(sb[4*c+2])
                        ^ xtime(sb[4*c+3]) ^ sb[4*c+3];
            mc[4*c+3] = xtime(sb[4*c]) ^ sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2]
                        ^ xtime(sb[4*c+3]);
         end else begin
            for (int r = 0; r < 4; r++) begin
               mc[4*c+r] = sb[4*c+r];
            end
         end
      end
   end

   // AddRoundKey.
   always_comb begin
      for (int n = 0; n < 16; n++) begin
         state_out[BLOCK_W-1-8*n -: 8] = mc[n] ^ round_key[BLOCK_W-1-8*n -: 8];
      end
   end

endmodule

/* design/aes_block_encrypt.sv */
`timescale 1ns / 1ps
// Channel  Direction  Word contents (lowest bit first)
// req      in         tuser: command; tdata: key_index, key_word, block_high, block_low
// rsp      out        tdata: cipher_high, cipher_low
//
// A load word writes the key memory at the edge where it is accepted.
// An encrypt word gets the initial key add with row 0, which is read at the accepting edge,
// in ST_FETCH, then one round per cycle in ST_ROUND, and its result waits in ST_DONE.
// Each round is fed by one key-row read, so the key memory read port sets the pace.
// Words are taken only when idle, so a new word waits until the last result is taken.
// Reset clears only the state register; key rows are undefined until loaded.
// A stalled result holds in the output register and blocks new words.
module aes_block_encrypt
   import aesbe_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUNDS_DEFAULT
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,   // key_index, key_word, block_high, block_low, pad
   input  logic         req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // cipher_high, cipher_low
);

   localparam int unsigned KEY_WORDS = 4 * (ROUNDS + 1);
   localparam int unsigned ROW_W = $clog2(ROUNDS + 1);

   logic [INDEX_W-1:0] key_index;
   logic [WORD_W-1:0]  key_word;
   logic [BLOCK_W-1:0] block_in;

   assign key_index = req_tdata[INDEX_W-1:0];
   assign key_word  = req_tdata[INDEX_W +: WORD_W];
   assign block_in  = {req_tdata[INDEX_W+WORD_W +: 64], req_tdata[INDEX_W+WORD_W+64 +: 64]};

   // Key memory: ROUNDS+1 rows, one per round key, written one 32-bit word column at a time.
   logic [BLOCK_W-1:0] key_mem [ROUNDS+1];
   logic [BLOCK_W-1:0] key_rd_ff;
   logic [ROW_W-1:0]   rd_row;
   logic               req_fire;
   logic               wr_en;
   logic [ROW_W-1:0]   wr_row;
   logic [1:0]         wr_col;

   assign req_fire = req_tvalid && req_tready;
   assign wr_en  = req_fire && (cmd_type'(req_tuser) == CMD_LOAD)
                   && (32'(key_index) < KEY_WORDS);
   assign wr_row = ROW_W'(key_index[INDEX_W-1:2]);
   assign wr_col = key_index[1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_row][BLOCK_W-1-WORD_W*wr_col -: WORD_W] <= key_word;
      end
      key_rd_ff <= key_mem[rd_row];
   end

   // Sequencer.
   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   round_ff, round_in;
   logic [BLOCK_W-1:0] data_ff, data_in;
   logic [BLOCK_W-1:0] round_out;

   aesbe_round u_round (
      .state_in  (data_ff),
      .round_key (key_rd_ff),
      .mix_en    (32'(round_ff) != ROUNDS),
      .state_out (round_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      round_ff <= round_in;
      data_ff  <= data_in;
   end

   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      data_in    = data_ff;
      rd_row     = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire && (cmd_type'(req_tuser) == CMD_ENCRYPT)) begin
               data_in  = block_in;
               round_in = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // Row 0 is on the read port; start row 1 reading.
            rd_row   = ROW_W'(1);
            data_in  = data_ff ^ key_rd_ff;
            round_in = ROW_W'(1);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            data_in  = round_out;
            round_in = round_ff + ROW_W'(1);
            if (32'(round_ff) == ROUNDS) begin
               state_in = ST_DONE;
            end else begin
               rd_row = round_ff + ROW_W'(1);
            end
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {data_ff[63:0], data_ff[127:64]};

   // Assertions.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input accepted while busy");
   a_fetch_to_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_ROUND) && (round_ff == ROW_W'(1)))
      else $error("round sequence broken");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff != '0) && (32'(round_ff) <= ROUNDS))
      else $error("round counter out of range");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

endmodule
